FILE: sv/sup_pkg.sv
// shared types, constants and coefficient table for the 2x sinc upsampler
// no dependencies; used by every module of the block
`default_nettype none

package sup_pkg;

	// sizing
	localparam int MAX_RADIUS = 8;
	localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int MEM_DEPTH  = 32;
	localparam int PTR_W      = $clog2(MEM_DEPTH);
	localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
	localparam int RAD_W      = 4;
	localparam int OFS_W      = $clog2(2 * MAX_RADIUS + 2);
	localparam int TI_W       = 4;
	localparam int SMP_W      = 16;
	localparam int WGT_W      = 17;
	localparam int PROD_W     = SMP_W + WGT_W;
	localparam int ACC_W      = 36;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	// register index codes (paddr bit 2)
	localparam logic REG_RADIUS = 1'b0;

	// reset value of the radius register
	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(8);

	// sinc(m+0.5) weights in q1.15, alternating sign, entry m for tap offsets -m and m+1
	localparam logic signed [SMP_W-1:0] SINC_ROM [16] = '{
		16'sd20861, -16'sd6954, 16'sd4172, -16'sd2980,
		16'sd2318,  -16'sd1896, 16'sd1605, -16'sd1391,
		16'sd1227,  -16'sd1098, 16'sd993,  -16'sd907,
		16'sd834,   -16'sd773,  16'sd719,  -16'sd673
	};

	// input beat
	typedef struct packed {
		logic signed [SMP_W-1:0] sample_in;
		logic                    end_of_signal;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    is_midpoint;
		logic                    final_out;
	} out_beat_t;

	// one classified input beat waiting for the back end
	typedef struct packed {
		logic [PTR_W-1:0] ptr;
		logic [CNT_W-1:0] avail;
		logic [RAD_W-1:0] radius;
		logic             last;
	} job_t;

	// window read request from the back end
	typedef struct packed {
		logic             en;
		logic [PTR_W-1:0] addr;
	} rd_req_t;

	// queue status seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: sv/sinc_upsampler_2x.sv
// top level of the 2x truncated-sinc upsampler: register port and wiring of front, queue, back
// depends on sup_pkg, sup_front, sup_queue, sup_back
//
//   channel   direction  handshake                        payload
//   sample    in         sample_valid / sample_stall      sup_pkg::in_beat_t
//   result    out        result_valid / result_stall      sup_pkg::out_beat_t
//   register  in         psel penable pwrite pready       paddr, pwdata, prdata (radius)
//
// a beat that is not the last of its signal yields one passed-through sample and one
// midpoint of at most 2r+1 taps, one tap a cycle through the single shared multiplier;
// a last beat adds each result of its flush tail.
// the front takes beats while the two-entry job queue has room, so it runs up to two beats
// ahead of the back end; a stalled result holds the back end only.
// reset clears control state only; the window memory needs no clearing pass.
`default_nettype none

module sinc_upsampler_2x (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire sup_pkg::in_beat_t      sample,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output sup_pkg::out_beat_t          result,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import sup_pkg::*;

	logic [RAD_W-1:0]        radius_q;
	logic                    reg_wr;
	logic                    push;
	logic                    pop;
	job_t                    push_job;
	job_t                    pop_job;
	q_stat_t                 q_stat;
	rd_req_t                 rd_req;
	logic signed [SMP_W-1:0] rd_data;

	// register port
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS);
	assign prdata = (paddr[2] == REG_RADIUS) ? PDATA_W'(radius_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (reg_wr) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	// front end
	sup_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.radius       (radius_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job),
		.rd_req       (rd_req),
		.rd_data      (rd_data)
	);

	// job queue
	sup_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	// back end
	sup_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_job      (pop_job),
		.pop          (pop),
		.rd_req       (rd_req),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: sv/sup_front.sv
// front end: takes input beats, stores samples in the window memory, classifies beats into jobs
// depends on sup_pkg
`default_nettype none

module sup_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire sup_pkg::in_beat_t sample,
	input  wire logic [3:0]        radius,
	input  wire sup_pkg::q_stat_t  q_stat,
	output logic                   push,
	output sup_pkg::job_t          push_job,
	input  wire sup_pkg::rd_req_t  rd_req,
	output logic signed [15:0]     rd_data
);
	import sup_pkg::*;

	logic signed [SMP_W-1:0] win_mem [MEM_DEPTH];
	logic [PTR_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [RAD_W-1:0]        act_radius_q;
	logic [RAD_W-1:0]        radius_clamped;
	logic [RAD_W-1:0]        radius_now;
	logic [PTR_W-1:0]        ptr_next;
	logic [CNT_W-1:0]        cnt_next;
	logic                    accept;

	// accept while the queue has room
	assign sample_stall = q_stat.full;
	assign accept       = sample_valid && !q_stat.full;

	// radius latched on the first beat of a signal
	assign radius_clamped = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
	assign radius_now     = (cnt_q == '0) ? radius_clamped : act_radius_q;
	assign ptr_next       = ptr_q + PTR_W'(1);
	assign cnt_next       = (cnt_q < CNT_W'(WIN_DEPTH)) ? cnt_q + CNT_W'(1) : cnt_q;

	// job for the back end
	assign push            = accept;
	assign push_job.ptr    = ptr_next;
	assign push_job.avail  = cnt_next;
	assign push_job.radius = radius_now;
	assign push_job.last   = sample.end_of_signal;

	// signal bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			cnt_q        <= '0;
			act_radius_q <= RAD_W'(MAX_RADIUS);
		end else if (accept) begin
			ptr_q        <= ptr_next;
			act_radius_q <= radius_now;
			cnt_q        <= sample.end_of_signal ? '0 : cnt_next;
		end
	end

	// window memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept) begin
			win_mem[ptr_next] <= sample.sample_in;
		end
		if (rd_req.en) begin
			rd_data <= win_mem[rd_req.addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/sup_queue.sv
// two-entry job queue between the front and back ends
// depends on sup_pkg
`default_nettype none

module sup_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sup_pkg::job_t  push_job,
	input  wire logic           pop,
	output sup_pkg::job_t       pop_job,
	output sup_pkg::q_stat_t    q_stat
);
	import sup_pkg::*;

	job_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_job      = slot_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full || pop)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job popped from an empty queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue level beyond its depth");

endmodule

`default_nettype wire

FILE: sv/sup_back.sv
// back end: walks each job's results, runs the shared multiply-accumulate over window taps
// depends on sup_pkg; reads the window memory held in sup_front
`default_nettype none

module sup_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sup_pkg::q_stat_t  q_stat,
	input  wire sup_pkg::job_t     pop_job,
	output logic                   pop,
	output sup_pkg::rd_req_t       rd_req,
	input  wire logic signed [15:0] rd_data,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output sup_pkg::out_beat_t     result
);
	import sup_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_TAPS, ST_DRAIN, ST_EMIT} state_t;

	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);
	localparam logic signed [WGT_W-1:0] UNITY    = WGT_W'(32768);

	state_t           state_q;
	job_t             job_q;
	logic [OFS_W-1:0] o_q;
	logic [OFS_W-1:0] o_lo_q;
	logic [OFS_W-1:0] m_q;
	logic [OFS_W-1:0] b_q;
	logic [OFS_W-1:0] b_hi_q;
	logic             unity_q;
	logic             first_q;
	logic             out_valid_q;
	out_beat_t        out_q;

	// tap pipeline
	logic                    vld_s1;
	logic                    unity_s1;
	logic                    first_s1;
	logic                    last_s1;
	logic [TI_W-1:0]         ti_s1;
	logic                    vld_s2;
	logic                    first_s2;
	logic                    last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// combinational helpers
	logic [RAD_W-1:0]        d_rad;
	logic [OFS_W-1:0]        d_new;
	logic [OFS_W-1:0]        o_lo_new;
	logic [OFS_W:0]          o_lim;
	logic                    o_skip;
	logic [OFS_W-1:0]        m_new;
	logic [OFS_W-1:0]        r_ext;
	logic [OFS_W-1:0]        b_lo_new;
	logic [OFS_W-1:0]        b_top;
	logic [OFS_W-1:0]        av_m1;
	logic [OFS_W-1:0]        b_hi_new;
	logic signed [OFS_W:0]   k_tap;
	logic [OFS_W-1:0]        ti_full;
	logic signed [WGT_W-1:0] weight_s1;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [ACC_W-1:0] quo;
	logic signed [SMP_W-1:0] sat_val;
	logic                    out_free;

	// result span of a new job: offsets d down to o_lo
	assign d_rad    = pop_job.radius;
	assign d_new    = (d_rad == '0) ? OFS_W'(1) : {d_rad, 1'b0};
	assign o_lo_new = pop_job.last ? '0 : d_new - OFS_W'(1);

	// offset beyond the samples of this signal
	assign o_lim  = {job_q.avail - CNT_W'(1), 1'b0};
	assign o_skip = {1'b0, o_q} > o_lim;

	// tap range of a midpoint
	assign m_new    = (o_q + OFS_W'(1)) >> 1;
	assign r_ext    = OFS_W'(job_q.radius);
	assign b_lo_new = (m_new > r_ext) ? m_new - r_ext : '0;
	assign b_top    = m_new + r_ext;
	assign av_m1    = job_q.avail - CNT_W'(1);
	assign b_hi_new = (b_top < av_m1) ? b_top : av_m1;

	// coefficient index from the tap offset
	assign k_tap   = $signed({1'b0, m_q}) - $signed({1'b0, b_q});
	assign ti_full = (k_tap > 0) ? OFS_W'(k_tap) - OFS_W'(1) : OFS_W'(-k_tap);

	// window read
	assign pop         = (state_q == ST_IDLE) && !q_stat.empty;
	assign rd_req.en   = (state_q == ST_TAPS);
	assign rd_req.addr = job_q.ptr - PTR_W'(b_q);

	// rounding half up and saturation
	assign rnd_sum = acc_q + RND_HALF;
	assign quo     = rnd_sum >>> 15;
	always_comb begin
		priority if (quo > SAT_HI) begin
			sat_val = SMP_W'(SAT_HI);
		end else if (quo < SAT_LO) begin
			sat_val = SMP_W'(SAT_LO);
		end else begin
			sat_val = quo[SMP_W-1:0];
		end
	end

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			o_q         <= '0;
			o_lo_q      <= '0;
			m_q         <= '0;
			b_q         <= '0;
			b_hi_q      <= '0;
			unity_q     <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a new beat loads in emit, a taken beat leaves otherwise
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						job_q   <= pop_job;
						o_q     <= d_new;
						o_lo_q  <= o_lo_new;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (o_skip) begin
						if (o_q == o_lo_q) begin
							state_q <= ST_IDLE;
						end else begin
							o_q <= o_q - OFS_W'(1);
						end
					end else begin
						unity_q <= ~o_q[0];
						first_q <= 1'b1;
						m_q     <= m_new;
						b_q     <= o_q[0] ? b_lo_new : o_q >> 1;
						b_hi_q  <= o_q[0] ? b_hi_new : o_q >> 1;
						state_q <= ST_TAPS;
					end
				end
				ST_TAPS: begin
					first_q <= 1'b0;
					b_q     <= b_q + OFS_W'(1);
					if (b_q == b_hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.sample_out <= sat_val;
						out_q.is_midpoint <= ~unity_q;
						out_q.final_out  <= job_q.last && (o_q == '0);
						if (o_q == o_lo_q) begin
							state_q <= ST_IDLE;
						end else begin
							o_q     <= o_q - OFS_W'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tap pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_TAPS);
			vld_s2 <= vld_s1;
		end
	end

	// tap pipeline payload: tag, product, accumulator
	assign weight_s1 = unity_s1 ? UNITY : WGT_W'(SINC_ROM[ti_s1]);

	always_ff @(posedge clk) begin
		unity_s1 <= unity_q;
		first_s1 <= first_q;
		last_s1  <= (b_q == b_hi_q);
		ti_s1    <= ti_full[TI_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= rd_data * weight_s1;
		if (vld_s2) begin
			acc_q <= (first_s2 ? ACC_W'(0) : acc_q)
				+ {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !vld_s1 && !vld_s2)
		else $error("result taken before the accumulator drained");

	a_tap_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAPS) |-> (b_q <= b_hi_q) && (b_q < OFS_W'(job_q.avail)))
		else $error("tap outside the samples of the signal");

	a_acc_source: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(state_q == ST_TAPS, 2))
		else $error("product without an issued tap");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_valid_q && result_stall |=> $stable(o_q))
		else $error("result offset advanced while the output was blocked");

endmodule

`default_nettype wire
